@@ src/msha_pkg.sv @@
// ----------------------------------------------------------------------------
// msha_pkg
// Shared constants for the Minkowski sum hull area block.
// ----------------------------------------------------------------------------
`default_nettype none

package msha_pkg;

  // default job size and coordinate width
  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_BITS_DEF = 21;

  // result width and accumulator width (area is summed modulo 2^ACC_W)
  localparam int AREA_W = 48;
  localparam int ACC_W  = 64;

endpackage : msha_pkg

`default_nettype wire

@@ src/msha_ram.sv @@
// ----------------------------------------------------------------------------
// msha_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module msha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : msha_ram

`default_nettype wire

@@ src/msha_cross.sv @@
// ----------------------------------------------------------------------------
// msha_cross
// Cross product unit: res = ax*by - ay*bx on one shared multiplier.
// The result is registered in res and flagged by done, which rises in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module msha_cross
  import msha_pkg::*;
#(
  parameter int MW = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [MW-1:0] ax,
  input  wire logic signed [MW-1:0] ay,
  input  wire logic signed [MW-1:0] bx,
  input  wire logic signed [MW-1:0] by,
  output logic                      done,
  output logic signed [ACC_W-1:0]   res
);

  logic signed [MW-1:0]   ax_r, ay_r, bx_r, by_r;
  logic [2:0]             ph_r;
  logic                   done_r;
  logic signed [2*MW-1:0] prod_r, p1_r;
  logic signed [2*MW-1:0] mul_a;
  logic signed [2*MW:0]   diff;
  logic signed [ACC_W-1:0] res_r;

  // first phase takes ax*by, second ay*bx
  assign mul_a = ph_r[0] ? ax_r * by_r : ay_r * bx_r;
  assign diff  = (2*MW+1)'(p1_r) - (2*MW+1)'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= '0;
      done_r <= 1'b0;
    end else begin
      ph_r   <= {ph_r[1:0], start};
      done_r <= ph_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ax_r <= ax;
      ay_r <= ay;
      bx_r <= bx;
      by_r <= by;
    end
    if (ph_r[0] || ph_r[1]) begin
      prod_r <= mul_a;
    end
    if (ph_r[1]) begin
      p1_r <= prod_r;
    end
    if (ph_r[2]) begin
      res_r <= ACC_W'(diff);
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule : msha_cross

`default_nettype wire

@@ src/minkowski_sum_hull_area.sv @@
// ----------------------------------------------------------------------------
// minkowski_sum_hull_area
// Loads points of set A and set B, then on the last point builds both convex
// hulls by monotone chain, sorts all hull edges by angle and returns twice
// the area of the Minkowski sum polygon.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake           payload
//  in_      input      in_valid/in_stall   point_set, coord_x, coord_y, last
//  out_     output     out_valid/out_stall twice_area, status
//
//  Points load at one per cycle into the point RAM while in_stall is low. The
//  last point starts the job: insertion sort of each set, hull build by
//  orientation tests, edge insertion sort and the area pass. in_stall is high
//  from the last point until the result is loaded into the output register;
//  the result holds while out_stall is high.
//  rst_n is synchronous; the RAMs need no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module minkowski_sum_hull_area
  import msha_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_point_set,
  input  wire logic signed [COORD_BITS-1:0] in_coord_x,
  input  wire logic signed [COORD_BITS-1:0] in_coord_y,
  input  wire logic                         in_last,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [AREA_W-1:0]                 out_twice_area,
  output logic                              out_status
);

  localparam int DEPTH = 2 * MAX_POINTS;
  localparam int SW    = $clog2(DEPTH);
  localparam int LW    = SW + 1;
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int PW    = 2 * COORD_BITS;
  localparam int EW    = COORD_BITS + 1;
  localparam int MW    = COORD_BITS + 3;
  localparam logic [SW-1:0] BASE_B = SW'(MAX_POINTS);

  typedef enum logic [27:0] {
    ST_IDLE   = 28'h0000001,
    ST_SET    = 28'h0000002,
    ST_NEXT   = 28'h0000004,
    ST_RD     = 28'h0000008,
    ST_KEY    = 28'h0000010,
    ST_CMP    = 28'h0000020,
    ST_CWT    = 28'h0000040,
    ST_INS    = 28'h0000080,
    ST_HINIT  = 28'h0000100,
    ST_HCRD   = 28'h0000200,
    ST_HCAND  = 28'h0000400,
    ST_HS0    = 28'h0000800,
    ST_HS1    = 28'h0001000,
    ST_HS2    = 28'h0002000,
    ST_HS3    = 28'h0004000,
    ST_HSW    = 28'h0008000,
    ST_HPUSH  = 28'h0010000,
    ST_HE0    = 28'h0020000,
    ST_HE1    = 28'h0040000,
    ST_HE2    = 28'h0080000,
    ST_HE3    = 28'h0100000,
    ST_HE4    = 28'h0200000,
    ST_AINIT  = 28'h0400000,
    ST_A1     = 28'h0800000,
    ST_A2     = 28'h1000000,
    ST_AW     = 28'h2000000,
    ST_AFIN   = 28'h4000000,
    ST_DONE   = 28'h8000000
  } state_t;

  // control state
  state_t          state_r, state_nxt;
  logic            set_r, set_nxt;
  logic [CW-1:0]   cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic            ovf_r, ovf_nxt;
  logic            out_valid_r, out_valid_nxt;

  // datapath registers
  logic            srt_edge_r, srt_edge_nxt;
  logic [LW-1:0]   i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [LW-1:0]   top_r, top_nxt, lim_r, lim_nxt, ecnt_r, ecnt_nxt;
  logic [SW-1:0]   cand_r, cand_nxt;
  logic            upper_r, upper_nxt;
  logic signed [EW-1:0] key_x_r, key_x_nxt, key_y_r, key_y_nxt;
  logic signed [EW-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [COORD_BITS-1:0] pi_x_r, pi_x_nxt, pi_y_r, pi_y_nxt;
  logic signed [COORD_BITS-1:0] po_x_r, po_x_nxt, po_y_r, po_y_nxt;
  logic signed [COORD_BITS-1:0] pv_x_r, pv_x_nxt, pv_y_r, pv_y_nxt;
  logic signed [MW-1:0] a_x_r, a_x_nxt, a_y_r, a_y_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [AREA_W-1:0] area_out_r, area_out_nxt;
  logic             stat_out_r, stat_out_nxt;

  // memory ports
  logic            pts_we, stk_we, edg_we;
  logic [SW-1:0]   pts_wa, pts_ra, stk_wa, stk_ra, edg_wa, edg_ra;
  logic [PW-1:0]   pts_wd, pts_rd;
  logic [SW-1:0]   stk_wd, stk_rd;
  logic [2*EW-1:0] edg_wd, edg_rd;

  // sort engine ports, routed to the point or edge RAM
  logic            srt_act, srt_we;
  logic [SW-1:0]   srt_wa, srt_ra;
  logic signed [EW-1:0] srt_wx, srt_wy;

  // cross unit
  logic                    xu_start, xu_done;
  logic signed [MW-1:0]    xu_ax, xu_ay, xu_bx, xu_by;
  logic signed [ACC_W-1:0] xu_res;

  // decoded read data and helpers
  logic signed [COORD_BITS-1:0] pts_x, pts_y;
  logic signed [EW-1:0]         edg_x, edg_y, srt_x, srt_y, dx, dy;
  logic [CW-1:0]                cur_n;
  logic [SW-1:0]                base, sbase, lastc;
  logic [LW-1:0]                sn;
  logic                         pos_less, edge_less, xu_pos;
  logic [1:0]                   hk, hc;

  function automatic logic [1:0] half_of(input logic signed [EW-1:0] x,
                                         input logic signed [EW-1:0] y);
    logic y_pos, x_pos;
    y_pos = !y[EW-1] && (y != '0);
    x_pos = !x[EW-1] && (x != '0);
    if (y[EW-1]) begin
      return 2'd0;
    end
    if (y_pos || x_pos) begin
      return 2'd1;
    end
    return 2'd2;
  endfunction

  assign pts_x = pts_rd[PW-1:COORD_BITS];
  assign pts_y = pts_rd[COORD_BITS-1:0];
  assign edg_x = edg_rd[2*EW-1:EW];
  assign edg_y = edg_rd[EW-1:0];
  assign srt_x = srt_edge_r ? edg_x : EW'(pts_x);
  assign srt_y = srt_edge_r ? edg_y : EW'(pts_y);
  assign dx    = EW'(pts_x) - EW'(pv_x_r);
  assign dy    = EW'(pts_y) - EW'(pv_y_r);

  assign cur_n = set_r ? cnt_b_r : cnt_a_r;
  assign base  = set_r ? BASE_B : '0;
  assign sbase = srt_edge_r ? '0 : base;
  assign sn    = srt_edge_r ? ecnt_r : LW'(cur_n);
  assign lastc = base + SW'(cur_n) - SW'(1);

  assign pos_less  = (key_x_r < srt_x) || ((key_x_r == srt_x) && (key_y_r < srt_y));
  assign xu_pos    = !xu_res[ACC_W-1] && (xu_res != '0);
  assign hk        = half_of(key_x_r, key_y_r);
  assign hc        = half_of(cur_x_r, cur_y_r);
  assign edge_less = (hk != hc) ? (hk < hc) : xu_pos;

  always_comb begin
    state_nxt     = state_r;
    set_nxt       = set_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    srt_edge_nxt  = srt_edge_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    top_nxt       = top_r;
    lim_nxt       = lim_r;
    ecnt_nxt      = ecnt_r;
    cand_nxt      = cand_r;
    upper_nxt     = upper_r;
    key_x_nxt     = key_x_r;
    key_y_nxt     = key_y_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    pi_x_nxt      = pi_x_r;
    pi_y_nxt      = pi_y_r;
    po_x_nxt      = po_x_r;
    po_y_nxt      = po_y_r;
    pv_x_nxt      = pv_x_r;
    pv_y_nxt      = pv_y_r;
    a_x_nxt       = a_x_r;
    a_y_nxt       = a_y_r;
    acc_nxt       = acc_r;
    area_out_nxt  = area_out_r;
    stat_out_nxt  = stat_out_r;

    pts_we = 1'b0;
    pts_wa = '0;
    pts_wd = '0;
    pts_ra = '0;
    stk_we = 1'b0;
    stk_wa = '0;
    stk_wd = '0;
    stk_ra = '0;
    edg_we = 1'b0;
    edg_wa = '0;
    edg_wd = '0;
    edg_ra = '0;

    srt_act = 1'b0;
    srt_we  = 1'b0;
    srt_wa  = '0;
    srt_wx  = '0;
    srt_wy  = '0;
    srt_ra  = '0;

    xu_start = 1'b0;
    xu_ax    = '0;
    xu_ay    = '0;
    xu_bx    = '0;
    xu_by    = '0;

    in_stall = (state_r != ST_IDLE);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!in_point_set) begin
            if (cnt_a_r < CW'(MAX_POINTS)) begin
              pts_we    = 1'b1;
              pts_wa    = SW'(cnt_a_r);
              pts_wd    = {in_coord_x, in_coord_y};
              cnt_a_nxt = cnt_a_r + CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            if (cnt_b_r < CW'(MAX_POINTS)) begin
              pts_we    = 1'b1;
              pts_wa    = BASE_B + SW'(cnt_b_r);
              pts_wd    = {in_coord_x, in_coord_y};
              cnt_b_nxt = cnt_b_r + CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (in_last) begin
            set_nxt   = 1'b0;
            ecnt_nxt  = '0;
            state_nxt = ST_SET;
          end
        end
      end

      ST_SET: begin
        if (cur_n >= CW'(2)) begin
          srt_edge_nxt = 1'b0;
          i_nxt        = LW'(1);
          state_nxt    = ST_RD;
        end else begin
          state_nxt = ST_NEXT;
        end
      end

      ST_NEXT: begin
        if (!set_r) begin
          set_nxt   = 1'b1;
          state_nxt = ST_SET;
        end else if (ecnt_r >= LW'(2)) begin
          srt_edge_nxt = 1'b1;
          i_nxt        = LW'(1);
          state_nxt    = ST_RD;
        end else begin
          state_nxt = ST_AINIT;
        end
      end

      // insertion sort over the point RAM or the edge RAM
      ST_RD: begin
        srt_act   = 1'b1;
        srt_ra    = sbase + i_r[SW-1:0];
        state_nxt = ST_KEY;
      end

      ST_KEY: begin
        srt_act   = 1'b1;
        key_x_nxt = srt_x;
        key_y_nxt = srt_y;
        j_nxt     = i_r;
        srt_ra    = sbase + i_r[SW-1:0] - SW'(1);
        state_nxt = ST_CMP;
      end

      ST_CMP: begin
        srt_act   = 1'b1;
        cur_x_nxt = srt_x;
        cur_y_nxt = srt_y;
        if (srt_edge_r) begin
          xu_start  = 1'b1;
          xu_ax     = MW'(key_x_r);
          xu_ay     = MW'(key_y_r);
          xu_bx     = MW'(srt_x);
          xu_by     = MW'(srt_y);
          state_nxt = ST_CWT;
        end else if (pos_less) begin
          // shift the larger entry up one place
          srt_we = 1'b1;
          srt_wa = sbase + j_r[SW-1:0];
          srt_wx = srt_x;
          srt_wy = srt_y;
          j_nxt  = j_r - LW'(1);
          if (j_r > LW'(1)) begin
            srt_ra    = sbase + SW'(j_r - LW'(2));
            state_nxt = ST_CMP;
          end else begin
            state_nxt = ST_INS;
          end
        end else begin
          state_nxt = ST_INS;
        end
      end

      ST_CWT: begin
        srt_act = 1'b1;
        if (xu_done) begin
          if (edge_less) begin
            srt_we = 1'b1;
            srt_wa = sbase + j_r[SW-1:0];
            srt_wx = cur_x_r;
            srt_wy = cur_y_r;
            j_nxt  = j_r - LW'(1);
            if (j_r > LW'(1)) begin
              srt_ra    = sbase + SW'(j_r - LW'(2));
              state_nxt = ST_CMP;
            end else begin
              state_nxt = ST_INS;
            end
          end else begin
            state_nxt = ST_INS;
          end
        end
      end

      ST_INS: begin
        srt_act = 1'b1;
        srt_we  = 1'b1;
        srt_wa  = sbase + j_r[SW-1:0];
        srt_wx  = key_x_r;
        srt_wy  = key_y_r;
        i_nxt   = i_r + LW'(1);
        if (i_r + LW'(1) < sn) begin
          srt_ra    = sbase + i_r[SW-1:0] + SW'(1);
          state_nxt = ST_KEY;
        end else if (srt_edge_r) begin
          state_nxt = ST_AINIT;
        end else begin
          state_nxt = ST_HINIT;
        end
      end

      // monotone chain: lower hull, then upper hull
      ST_HINIT: begin
        stk_we    = 1'b1;
        stk_wa    = '0;
        stk_wd    = base;
        top_nxt   = LW'(1);
        lim_nxt   = LW'(1);
        cand_nxt  = base + SW'(1);
        upper_nxt = 1'b0;
        state_nxt = ST_HCRD;
      end

      ST_HCRD: begin
        pts_ra    = cand_r;
        state_nxt = ST_HCAND;
      end

      ST_HCAND: begin
        pi_x_nxt = pts_x;
        pi_y_nxt = pts_y;
        if (top_r > lim_r) begin
          state_nxt = ST_HS0;
        end else begin
          state_nxt = ST_HPUSH;
        end
      end

      ST_HS0: begin
        stk_ra    = SW'(top_r - LW'(2));
        state_nxt = ST_HS1;
      end

      ST_HS1: begin
        pts_ra    = stk_rd;
        stk_ra    = SW'(top_r - LW'(1));
        state_nxt = ST_HS2;
      end

      ST_HS2: begin
        po_x_nxt  = pts_x;
        po_y_nxt  = pts_y;
        pts_ra    = stk_rd;
        state_nxt = ST_HS3;
      end

      ST_HS3: begin
        xu_start  = 1'b1;
        xu_ax     = MW'(pts_x) - MW'(po_x_r);
        xu_ay     = MW'(pts_y) - MW'(po_y_r);
        xu_bx     = MW'(pi_x_r) - MW'(po_x_r);
        xu_by     = MW'(pi_y_r) - MW'(po_y_r);
        state_nxt = ST_HSW;
      end

      ST_HSW: begin
        if (xu_done) begin
          if (!xu_pos) begin
            // drop a clockwise or collinear top
            top_nxt = top_r - LW'(1);
            if (top_r - LW'(1) > lim_r) begin
              state_nxt = ST_HS0;
            end else begin
              state_nxt = ST_HPUSH;
            end
          end else begin
            state_nxt = ST_HPUSH;
          end
        end
      end

      ST_HPUSH: begin
        stk_we  = 1'b1;
        stk_wa  = top_r[SW-1:0];
        stk_wd  = cand_r;
        top_nxt = top_r + LW'(1);
        if (!upper_r) begin
          if (cand_r == lastc) begin
            upper_nxt = 1'b1;
            lim_nxt   = top_r + LW'(1);
            cand_nxt  = lastc - SW'(1);
          end else begin
            cand_nxt = cand_r + SW'(1);
          end
          state_nxt = ST_HCRD;
        end else if (cand_r == base) begin
          state_nxt = ST_HE0;
        end else begin
          cand_nxt  = cand_r - SW'(1);
          state_nxt = ST_HCRD;
        end
      end

      // walk the stack and store nonzero edge vectors
      ST_HE0: begin
        stk_ra    = '0;
        k_nxt     = LW'(1);
        state_nxt = ST_HE1;
      end

      ST_HE1: begin
        pts_ra    = stk_rd;
        state_nxt = ST_HE2;
      end

      ST_HE2: begin
        pv_x_nxt  = pts_x;
        pv_y_nxt  = pts_y;
        stk_ra    = k_r[SW-1:0];
        state_nxt = ST_HE3;
      end

      ST_HE3: begin
        pts_ra    = stk_rd;
        state_nxt = ST_HE4;
      end

      ST_HE4: begin
        if (((dx != '0) || (dy != '0)) && (ecnt_r < LW'(DEPTH))) begin
          edg_we   = 1'b1;
          edg_wa   = ecnt_r[SW-1:0];
          edg_wd   = {dx, dy};
          ecnt_nxt = ecnt_r + LW'(1);
        end
        pv_x_nxt = pts_x;
        pv_y_nxt = pts_y;
        k_nxt    = k_r + LW'(1);
        if (k_r + LW'(1) < top_r) begin
          stk_ra    = SW'(k_r + LW'(1));
          state_nxt = ST_HE3;
        end else begin
          state_nxt = ST_NEXT;
        end
      end

      // fan area over prefix sums of the sorted edges
      ST_AINIT: begin
        acc_nxt = '0;
        if (ecnt_r < LW'(3)) begin
          state_nxt = ST_AFIN;
        end else begin
          edg_ra    = SW'(1);
          k_nxt     = LW'(2);
          state_nxt = ST_A1;
        end
      end

      ST_A1: begin
        a_x_nxt   = MW'(edg_x);
        a_y_nxt   = MW'(edg_y);
        edg_ra    = k_r[SW-1:0];
        state_nxt = ST_A2;
      end

      ST_A2: begin
        cur_x_nxt = edg_x;
        cur_y_nxt = edg_y;
        xu_start  = 1'b1;
        xu_ax     = a_x_r;
        xu_ay     = a_y_r;
        xu_bx     = MW'(edg_x);
        xu_by     = MW'(edg_y);
        state_nxt = ST_AW;
      end

      ST_AW: begin
        if (xu_done) begin
          acc_nxt = acc_r + ACC_W'(unsigned'(xu_res));
          a_x_nxt = a_x_r + MW'(cur_x_r);
          a_y_nxt = a_y_r + MW'(cur_y_r);
          k_nxt   = k_r + LW'(1);
          if (k_r + LW'(1) < ecnt_r) begin
            edg_ra    = SW'(k_r + LW'(1));
            state_nxt = ST_A2;
          end else begin
            state_nxt = ST_AFIN;
          end
        end
      end

      ST_AFIN: begin
        if (acc_r[ACC_W-1]) begin
          acc_nxt = '0 - acc_r;
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          area_out_nxt  = acc_r[AREA_W-1:0];
          stat_out_nxt  = ovf_r;
          cnt_a_nxt     = '0;
          cnt_b_nxt     = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (srt_act) begin
      if (srt_edge_r) begin
        edg_we = srt_we;
        edg_wa = srt_wa;
        edg_wd = {srt_wx, srt_wy};
        edg_ra = srt_ra;
      end else begin
        pts_we = srt_we;
        pts_wa = srt_wa;
        pts_wd = {srt_wx[COORD_BITS-1:0], srt_wy[COORD_BITS-1:0]};
        pts_ra = srt_ra;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      set_r       <= 1'b0;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      set_r       <= set_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    srt_edge_r <= srt_edge_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    top_r      <= top_nxt;
    lim_r      <= lim_nxt;
    ecnt_r     <= ecnt_nxt;
    cand_r     <= cand_nxt;
    upper_r    <= upper_nxt;
    key_x_r    <= key_x_nxt;
    key_y_r    <= key_y_nxt;
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    pi_x_r     <= pi_x_nxt;
    pi_y_r     <= pi_y_nxt;
    po_x_r     <= po_x_nxt;
    po_y_r     <= po_y_nxt;
    pv_x_r     <= pv_x_nxt;
    pv_y_r     <= pv_y_nxt;
    a_x_r      <= a_x_nxt;
    a_y_r      <= a_y_nxt;
    acc_r      <= acc_nxt;
    area_out_r <= area_out_nxt;
    stat_out_r <= stat_out_nxt;
  end

  msha_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_pts (
    .clk   (clk),
    .we    (pts_we),
    .waddr (pts_wa),
    .wdata (pts_wd),
    .raddr (pts_ra),
    .rdata (pts_rd)
  );

  msha_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_stk (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_wa),
    .wdata (stk_wd),
    .raddr (stk_ra),
    .rdata (stk_rd)
  );

  msha_ram #(.WIDTH(2*EW), .DEPTH(DEPTH)) u_edg (
    .clk   (clk),
    .we    (edg_we),
    .waddr (edg_wa),
    .wdata (edg_wd),
    .raddr (edg_ra),
    .rdata (edg_rd)
  );

  msha_cross #(.MW(MW)) u_cross (
    .clk   (clk),
    .rst_n (rst_n),
    .start (xu_start),
    .ax    (xu_ax),
    .ay    (xu_ay),
    .bx    (xu_bx),
    .by    (xu_by),
    .done  (xu_done),
    .res   (xu_res)
  );

  assign out_valid      = out_valid_r;
  assign out_twice_area = area_out_r;
  assign out_status     = stat_out_r;

endmodule : minkowski_sum_hull_area

`default_nettype wire

@@ verif/minkowski_sum_hull_area_tb.sv @@
// ----------------------------------------------------------------------------
// minkowski_sum_hull_area_tb
// Drives point jobs into the Minkowski sum hull area block and checks each
// returned doubled area and overflow status against an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class area_scoreboard;
  localparam int MAXP = msha_pkg::MAX_POINTS_DEF;
  longint px[2][MAXP];
  longint py[2][MAXP];
  int cnt[2];
  bit ovf;
  logic [47:0] exp_area[$];
  bit exp_stat[$];
  int errors;
  int results_seen;

  function void clear_job();
    cnt[0] = 0;
    cnt[1] = 0;
    ovf = 0;
  endfunction

  // edge lists are built into ex/ey by the hull pass
  function void hull_edges(int s, ref longint ex[$], ref longint ey[$]);
    longint sx[$];
    longint sy[$];
    int stk[$];
    int n, lower;
    longint kx, ky, cx;
    n = cnt[s];
    if (n == 0) return;
    for (int i = 0; i < n; i++) begin
      kx = px[s][i];
      ky = py[s][i];
      sx.push_back(kx);
      sy.push_back(ky);
      for (int j = i; j > 0; j--) begin
        if (sx[j] < sx[j-1] || (sx[j] == sx[j-1] && sy[j] < sy[j-1])) begin
          kx = sx[j]; sx[j] = sx[j-1]; sx[j-1] = kx;
          ky = sy[j]; sy[j] = sy[j-1]; sy[j-1] = ky;
        end else break;
      end
    end
    stk.push_back(0);
    for (int i = 1; i < n; i++) begin
      while (stk.size() > 1) begin
        cx = (sx[stk[$]] - sx[stk[$-1]]) * (sy[i] - sy[stk[$-1]])
           - (sy[stk[$]] - sy[stk[$-1]]) * (sx[i] - sx[stk[$-1]]);
        if (cx <= 0) void'(stk.pop_back()); else break;
      end
      stk.push_back(i);
    end
    lower = stk.size();
    for (int i = n - 2; i >= 0; i--) begin
      while (stk.size() > lower) begin
        cx = (sx[stk[$]] - sx[stk[$-1]]) * (sy[i] - sy[stk[$-1]])
           - (sy[stk[$]] - sy[stk[$-1]]) * (sx[i] - sx[stk[$-1]]);
        if (cx <= 0) void'(stk.pop_back()); else break;
      end
      stk.push_back(i);
    end
    for (int i = 1; i < stk.size(); i++) begin
      kx = sx[stk[i]] - sx[stk[i-1]];
      ky = sy[stk[i]] - sy[stk[i-1]];
      // drop zero edges; the edge store holds two full sets at most
      if ((kx != 0 || ky != 0) && ex.size() < 2 * MAXP) begin
        ex.push_back(kx);
        ey.push_back(ky);
      end
    end
  endfunction

  function int half_of(longint x, longint y);
    if (y < 0) return 0;
    if (y > 0 || x > 0) return 1;
    return 2;
  endfunction

  function bit angle_less(longint x1, longint y1, longint x2, longint y2);
    int h1, h2;
    h1 = half_of(x1, y1);
    h2 = half_of(x2, y2);
    if (h1 != h2) return h1 < h2;
    return x1 * y2 - y1 * x2 > 0;
  endfunction

  function void note_point(bit s, longint x, longint y, bit lst);
    longint ex[$];
    longint ey[$];
    longint t;
    logic [63:0] acc;
    if (cnt[s] < MAXP) begin
      px[s][cnt[s]] = x;
      py[s][cnt[s]] = y;
      cnt[s]++;
    end else ovf = 1;
    if (!lst) return;
    hull_edges(0, ex, ey);
    hull_edges(1, ex, ey);
    for (int i = 1; i < ex.size(); i++)
      for (int j = i; j > 0; j--) begin
        if (angle_less(ex[j], ey[j], ex[j-1], ey[j-1])) begin
          t = ex[j]; ex[j] = ex[j-1]; ex[j-1] = t;
          t = ey[j]; ey[j] = ey[j-1]; ey[j-1] = t;
        end else break;
      end
    for (int i = 1; i < ex.size(); i++) begin
      ex[i] += ex[i-1];
      ey[i] += ey[i-1];
    end
    acc = 0;
    for (int i = 1; i + 1 < ex.size(); i++)
      acc += 64'((ex[i] - ex[0]) * (ey[i+1] - ey[0]) - (ey[i] - ey[0]) * (ex[i+1] - ex[0]));
    if (acc[63]) acc = -acc;
    exp_area.push_back(acc[47:0]);
    exp_stat.push_back(ovf);
    clear_job();
  endfunction

  task report(string what);
    $display("MISMATCH %s", what);
    errors++;
  endtask

  task check_result(logic [47:0] area, logic stat);
    results_seen++;
    if (exp_area.size() == 0) begin
      report($sformatf("unexpected result area=%0d", area));
      return;
    end
    if (area !== exp_area[0])
      report($sformatf("twice_area got %0d want %0d", area, exp_area[0]));
    if (stat !== exp_stat[0])
      report($sformatf("status got %0d want %0d", stat, exp_stat[0]));
    void'(exp_area.pop_front());
    void'(exp_stat.pop_front());
  endtask
endclass

module minkowski_sum_hull_area_tb;
  import msha_pkg::*;
  localparam int CB = COORD_BITS_DEF;
  localparam int WATCHDOG = 4000000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_point_set = 0;
  logic signed [CB-1:0] in_coord_x = 0;
  logic signed [CB-1:0] in_coord_y = 0;
  logic in_last = 0;
  logic out_stall = 0;
  wire in_stall;
  wire out_valid;
  wire [AREA_W-1:0] out_twice_area;
  wire out_status;

  area_scoreboard sb;
  bit quiet_idle = 0;
  bit hold_out = 0;
  int idle_count = 0;
  int stall_left = 0;
  int points_sent = 0;

  minkowski_sum_hull_area dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_point_set(in_point_set), .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .in_last(in_last), .out_valid(out_valid), .out_stall(out_stall),
    .out_twice_area(out_twice_area), .out_status(out_status)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver: random stall bursts, or a long hold when asked
  always @(posedge clk) begin
    if (out_valid && !out_stall && rst_n) sb.check_result(out_twice_area, out_status);
    if (hold_out) begin
      out_stall <= 1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1;
    end else if (!quiet_idle && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_point(bit s, logic signed [CB-1:0] x, logic signed [CB-1:0] y, bit lst);
    int gap;
    if (!quiet_idle && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_point_set <= s;
    in_coord_x <= x;
    in_coord_y <= y;
    in_last <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_point(s, x, y, lst);
    points_sent++;
  endtask

  task automatic end_send();
    in_valid <= 0;
  endtask

  task automatic wait_drained();
    end_send();
    @(posedge clk);
    while (sb.exp_area.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [CB-1:0] rnd_coord(int span);
    if (span == 0) return CB'($urandom);
    return CB'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // random job: mostly small sets, narrow or full range coordinates
  task automatic random_job(int na, int nb, int span);
    int total;
    bit s;
    total = na + nb;
    for (int i = 0; i < total; i++) begin
      s = (i < na) ? 0 : 1;
      if ($urandom_range(0, 3) == 0) s = $urandom_range(0, 1);
      send_point(s, rnd_coord(span), rnd_coord(span), i == total - 1);
    end
  endtask

  initial begin
    int na, nb, span;
    sb = new();
    sb.clear_job();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // lone point, then a lone point in set B
    send_point(0, 0, 0, 1);
    send_point(1, 5, -3, 1);
    // unit square in set A, a triangle with a repeated point in set B
    send_point(0, 0, 0, 0); send_point(0, 1, 0, 0);
    send_point(0, 1, 1, 0); send_point(0, 0, 1, 0);
    send_point(1, 0, 0, 0); send_point(1, 2, 0, 0);
    send_point(1, 1, 1, 0); send_point(1, 1, 1, 1);
    // collinear set A with duplicates, segment in set B
    send_point(0, -4, -4, 0); send_point(0, 0, 0, 0); send_point(0, 0, 0, 0);
    send_point(0, 4, 4, 0); send_point(1, 3, -7, 0); send_point(1, -3, 7, 1);
    // coordinate extremes
    send_point(0, -1048576, -1048576, 0); send_point(0, 1048575, -1048576, 0);
    send_point(0, 1048575, 1048575, 0); send_point(0, -1048576, 1048575, 0);
    send_point(1, -1048576, 1048575, 0); send_point(1, 1048575, -1048576, 0);
    send_point(1, 1048575, 1048575, 1);
    wait_drained();

    // long receiver hold while the sender keeps offering jobs
    hold_out <= 1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_out <= 0;
      end
      for (int j = 0; j < 4; j++) random_job(3, 3, 100);
    join
    wait_drained();

    while (points_sent < 600) begin
      if (points_sent > 520) quiet_idle = 1;
      na = $urandom_range(0, 8);
      nb = $urandom_range(0, 8);
      if (na + nb == 0) na = 1;
      span = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 1000);
      random_job(na, nb, span);
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    wait_drained();
    repeat (200) @(posedge clk);

    $display("Ran %0d points and %0d jobs: degenerate sets, extremes, stalls.",
             points_sent, sb.results_seen);
    if (sb.errors == 0 && sb.exp_area.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
